/* src/e2g_pkg.sv */
// Package for the equatorial to galactic converter: widths, cell payload types,
// CORDIC arctangent table, gain and rotation constants built at elaboration.
// Used by the CORDIC cells and the top level; depends on nothing.
package e2g_pkg;

	localparam int ANG_W  = 32;                 // internal binary angle, turn = 2^ANG_W
	localparam int NS     = 32;                 // CORDIC stages per chain
	localparam int SW     = 34;                 // signed Q30 vector and angle accumulator width
	localparam int STG_W  = $clog2(NS);
	localparam int VQ     = 30;

	typedef logic [ANG_W-1:0] atan_tab_t [NS];

	typedef struct packed {
		logic [1:0]           quad;
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] z;
	} rot_t;

	typedef struct packed {
		logic                 zero;
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] z;
		logic [SW-1:0]        side;
	} vec_t;

	// restoring long division, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
		input int bits);
		logic [63:0] q;
		logic [63:0] r;
		q = udiv(num, den);
		r = num - q * den;
		for (int i = 0; i < bits; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] frac_div_round(input logic [63:0] num,
		input logic [63:0] den, input int bits);
		return (frac_div(num, den, bits + 1) + 64'd1) >> 1;
	endfunction

	// atan(2^-i) in Q62 radians by its series, i >= 1
	function automatic logic [63:0] atan_pow2_q62(input int i);
		logic [63:0]        t;
		logic signed [63:0] sum;
		logic [63:0]        term;
		logic [63:0]        k;
		t   = (64'd1 << 62) >> i;
		sum = '0;
		k   = '0;
		while (t != 0) begin
			term = udiv(t, 2 * k + 64'd1);
			if (k[0])
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
			t = (2 * i < 64) ? (t >> (2 * i)) : 64'd0;
			k = k + 64'd1;
		end
		return sum;
	endfunction

	function automatic logic [63:0] quarter_pi_q62();
		logic [63:0]        t;
		logic [63:0]        k;
		logic [63:0]        term;
		logic signed [63:0] third;
		t     = udiv(64'd1 << 62, 64'd3);
		k     = '0;
		third = '0;
		while (t != 0) begin
			term = udiv(t, 2 * k + 64'd1);
			if (k[0])
				third = third - $signed(term);
			else
				third = third + $signed(term);
			t = udiv(t, 64'd9);
			k = k + 64'd1;
		end
		return atan_pow2_q62(1) + third;
	endfunction

	localparam logic [63:0] PI4_Q62 = quarter_pi_q62();

	function automatic atan_tab_t build_atan();
		atan_tab_t   tab;
		logic [63:0] r;
		logic [63:0] a;
		for (int i = 0; i < NS; i++) begin
			r      = (i == 0) ? PI4_Q62 : atan_pow2_q62(i);
			a      = frac_div_round(r, PI4_Q62, ANG_W - 3);
			tab[i] = a[ANG_W-1:0];
		end
		return tab;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		logic [63:0] w;
		res = '0;
		w   = v;
		b   = 64'd1 << 62;
		while (b > w)
			b = b >> 2;
		while (b != 0) begin
			if (w >= res + b) begin
				w   = w - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] build_gain();
		logic [63:0] p;
		logic [63:0] g;
		p = 64'd1 << 60;
		for (int i = 0; i < NS; i++)
			if (2 * i < 64)
				p = p + (p >> (2 * i));
		g = isqrt64(p);
		return (udiv(64'd1 << 61, g) + 64'd1) >> 1;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

	localparam logic [63:0] K_GAIN_64 = build_gain();
	localparam logic [63:0] TILT_S_64 =
		frac_div_round(64'd88998808748, 64'd100000000000, VQ);
	localparam logic [63:0] TILT_C_64 =
		frac_div_round(64'd45598377618, 64'd100000000000, VQ);
	localparam logic [63:0] NODE_LON_64 =
		frac_div_round(frac_div(64'd49368292465, 64'd80000000000, 62), PI4_Q62, ANG_W);
	localparam logic [63:0] LON_OFF_64 =
		frac_div_round(frac_div(64'd57477043300, 64'd800000000000, 62), PI4_Q62, ANG_W);

	localparam logic signed [SW-1:0] K_GAIN  = $signed(K_GAIN_64[SW-1:0]);
	localparam logic signed [SW-1:0] TILT_S  = $signed(TILT_S_64[SW-1:0]);
	localparam logic signed [SW-1:0] TILT_C  = $signed(TILT_C_64[SW-1:0]);
	localparam logic [ANG_W-1:0]     NODE_LON = NODE_LON_64[ANG_W-1:0];
	localparam logic [ANG_W-1:0]     LON_OFF  = LON_OFF_64[ANG_W-1:0];

	// Q30 product with round half up, floor shift
	function automatic logic signed [SW-1:0] fmul(input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b);
		logic signed [2*SW-1:0] p;
		p = a * b + (2*SW)'(64'sd1 <<< (VQ - 1));
		return p[SW+VQ-1:VQ];
	endfunction

endpackage

/* src/e2g_rot_cell.sv */
// One rotation-mode CORDIC cell: a single micro-rotation and its register.
// Depends on e2g_pkg.
module e2g_rot_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [e2g_pkg::STG_W-1:0] stage,
	input  logic                      d_v,
	input  e2g_pkg::rot_t             d,
	output logic                      q_v,
	output e2g_pkg::rot_t             q
);
	import e2g_pkg::*;

	logic                 v_q;
	rot_t                 data_q;
	rot_t                 nxt;
	logic signed [SW-1:0] dx;
	logic signed [SW-1:0] dy;
	logic signed [SW-1:0] atn;

	always_comb begin
		dx       = d.y >>> stage;
		dy       = d.x >>> stage;
		atn      = $signed(SW'(ATAN_TAB[stage]));
		nxt.quad = d.quad;
		if (!d.z[SW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - atn;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + atn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d_v;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	assign q_v = v_q;
	assign q   = data_q;

endmodule

/* src/e2g_vec_cell.sv */
// One vectoring-mode CORDIC cell: drives y toward zero and accumulates the angle.
// Depends on e2g_pkg.
module e2g_vec_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [e2g_pkg::STG_W-1:0] stage,
	input  logic                      d_v,
	input  e2g_pkg::vec_t             d,
	output logic                      q_v,
	output e2g_pkg::vec_t             q
);
	import e2g_pkg::*;

	logic                 v_q;
	vec_t                 data_q;
	vec_t                 nxt;
	logic signed [SW-1:0] dx;
	logic signed [SW-1:0] dy;
	logic signed [SW-1:0] atn;

	always_comb begin
		dx       = d.y >>> stage;
		dy       = d.x >>> stage;
		atn      = $signed(SW'(ATAN_TAB[stage]));
		nxt.zero = d.zero;
		nxt.side = d.side;
		if (!d.y[SW-1]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + atn;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - atn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d_v;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	assign q_v = v_q;
	assign q   = data_q;

endmodule

/* src/equatorial_to_galactic_core.sv */
// Equatorial (J2000) to galactic converter, top level.
// Depends on e2g_pkg, e2g_rot_cell and e2g_vec_cell.
//
// Takes one beat per cycle while s_tready is high and returns one beat per
// input beat, in order. The pipeline holds an input register, two chains of 32
// rotation cells computing both sine/cosine pairs, two multiply stages for the
// pole-tilt rotation, 32 vectoring cells for the longitude, one scaling stage,
// 32 vectoring cells for the latitude, and the output register. A skid register
// behind the last cell keeps the pipeline running while the output is stalled
// until it holds a beat; then s_tready drops until the output is taken.
module equatorial_to_galactic_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] right_ascension, [63:32] declination
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] galactic_longitude, [63:32] galactic_latitude
);
	import e2g_pkg::*;

	logic en;

	// input stage
	logic             v_s1;
	logic [ANG_W-1:0] ra_s1;
	logic [ANG_W-1:0] de_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s1 <= s_tdata[31:0] - NODE_LON;
			de_s1 <= s_tdata[63:32];
		end
	end

	// rotation chains
	logic ra_v [NS+1];
	logic de_v [NS+1];
	rot_t ra_c [NS+1];
	rot_t de_c [NS+1];

	always_comb begin
		ra_v[0]      = v_s1;
		ra_c[0].quad = ra_s1[ANG_W-1:ANG_W-2];
		ra_c[0].x    = K_GAIN;
		ra_c[0].y    = '0;
		ra_c[0].z    = $signed(SW'(ra_s1[ANG_W-3:0]));
		de_v[0]      = v_s1;
		de_c[0].quad = de_s1[ANG_W-1:ANG_W-2];
		de_c[0].x    = K_GAIN;
		de_c[0].y    = '0;
		de_c[0].z    = $signed(SW'(de_s1[ANG_W-3:0]));
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		e2g_rot_cell u_ra (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(STG_W'(i)),
			.d_v(ra_v[i]), .d(ra_c[i]), .q_v(ra_v[i+1]), .q(ra_c[i+1])
		);
		e2g_rot_cell u_de (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(STG_W'(i)),
			.d_v(de_v[i]), .d(de_c[i]), .q_v(de_v[i+1]), .q(de_c[i+1])
		);
	end

	function automatic void quad_fix(input rot_t r, output logic signed [SW-1:0] c,
		output logic signed [SW-1:0] s);
		case (r.quad)
			2'd0: begin c = r.x;  s = r.y;  end
			2'd1: begin c = -r.y; s = r.x;  end
			2'd2: begin c = -r.x; s = -r.y; end
			default: begin c = r.y; s = -r.x; end
		endcase
	endfunction

	logic signed [SW-1:0] ca, sa, cd, sd;

	always_comb begin
		quad_fix(ra_c[NS], ca, sa);
		quad_fix(de_c[NS], cd, sd);
	end

	// tilt rotation, first products
	logic                 v_s2;
	logic signed [SW-1:0] cdsa_s2, xr_s2, sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= ra_v[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cdsa_s2 <= fmul(cd, sa);
			xr_s2   <= fmul(cd, ca);
			sd_s2   <= sd;
		end
	end

	logic                 v_s3;
	logic signed [SW-1:0] xr_s3, yr_s3, zr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s3 <= xr_s2;
			yr_s3 <= fmul(TILT_C, cdsa_s2) + fmul(TILT_S, sd_s2);
			zr_s3 <= fmul(TILT_C, sd_s2) - fmul(TILT_S, cdsa_s2);
		end
	end

	// turn a vector with negative x by a half turn; flag the zero vector
	function automatic vec_t vec_pre(input logic signed [SW-1:0] x,
		input logic signed [SW-1:0] y, input logic [SW-1:0] side);
		vec_t r;
		r.side = side;
		r.zero = (x == '0) && (y == '0);
		if (x[SW-1]) begin
			r.x = -x;
			r.y = -y;
			r.z = $signed(SW'(64'd1 << (ANG_W - 1)));
		end else begin
			r.x = x;
			r.y = y;
			r.z = '0;
		end
		return r;
	endfunction

	// longitude chain, latitude z rides along
	logic l_v [NS+1];
	vec_t l_c [NS+1];

	assign l_v[0] = v_s3;
	assign l_c[0] = vec_pre(xr_s3, yr_s3, zr_s3);

	for (genvar i = 0; i < NS; i++) begin : g_lon
		e2g_vec_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(STG_W'(i)),
			.d_v(l_v[i]), .d(l_c[i]), .q_v(l_v[i+1]), .q(l_c[i+1])
		);
	end

	// scale magnitude to the hypot, add longitude offset
	logic                 v_s4;
	logic signed [SW-1:0] hx_s4, zr_s4;
	logic [ANG_W-1:0]     lon_s4;
	logic [ANG_W-1:0]     la;

	assign la = l_c[NS].zero ? '0 : l_c[NS].z[ANG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= l_v[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s4  <= fmul(l_c[NS].x, K_GAIN);
			zr_s4  <= l_c[NS].side;
			lon_s4 <= la + LON_OFF;
		end
	end

	// latitude chain, longitude rides along
	logic b_v [NS+1];
	vec_t b_c [NS+1];

	assign b_v[0] = v_s4;
	assign b_c[0] = vec_pre(hx_s4, zr_s4, SW'(lon_s4));

	for (genvar i = 0; i < NS; i++) begin : g_lat
		e2g_vec_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(STG_W'(i)),
			.d_v(b_v[i]), .d(b_c[i]), .q_v(b_v[i+1]), .q(b_c[i+1])
		);
	end

	logic signed [31:0] b32;
	logic signed [31:0] lat;
	logic [63:0]        last_data;
	logic               last_v;

	always_comb begin
		b32 = b_c[NS].zero ? 32'sd0 : $signed(b_c[NS].z[31:0]);
		if (b32 > 32'sd1073741824)
			lat = 32'sd1073741824;
		else if (b32 < -32'sd1073741824)
			lat = -32'sd1073741824;
		else
			lat = b32;
		last_data = {lat, b_c[NS].side[31:0]};
		last_v    = b_v[NS];
	end

	// output register and skid
	logic        out_v_q, skid_v_q;
	logic [63:0] out_q, skid_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= last_v;
			end
		end else if (last_v && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : last_data;
		end else if (last_v && en) begin
			skid_q <= last_data;
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

/* src/e2g_checker.sv */
// Port-level checks for equatorial_to_galactic_core, bound to the top level.
// Depends on nothing but the top level's ports.
module e2g_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// latitude stays within a quarter turn
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[63:32]) <= 32'sd1073741824) &&
			($signed(m_tdata[63:32]) >= -32'sd1073741824))
		else $error("latitude out of range");

	// input backpressure only follows an output stall
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output stall");

	// while the skid holds a beat, an output beat is on offer
	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output beat");

endmodule

bind equatorial_to_galactic_core e2g_checker u_e2g_checker (.*);
